// ===== src/cc_pkg.sv =====
// Shared types, register indexes, selector codes and mux word decode of the colour combiner.
package cc_pkg;

    // Default channel width; 255 stands for 1.0 at eight bits
    localparam int CHANNEL_BITS_DEF = 8;

    // Configuration port
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_MUX_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MUX_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRIM     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENV      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOD      = 3'd4;

    // Colour A/B/C selector codes (C reads K5 at the zero code)
    localparam logic [3:0] CSEL_COMBINED    = 4'd0;
    localparam logic [3:0] CSEL_TEXEL0      = 4'd1;
    localparam logic [3:0] CSEL_TEXEL1      = 4'd2;
    localparam logic [3:0] CSEL_PRIM        = 4'd3;
    localparam logic [3:0] CSEL_SHADE       = 4'd4;
    localparam logic [3:0] CSEL_ENV         = 4'd5;
    localparam logic [3:0] CSEL_ONE         = 4'd6;
    localparam logic [3:0] CSEL_COMB_ALPHA  = 4'd7;
    localparam logic [3:0] CSEL_TEX0_ALPHA  = 4'd8;
    localparam logic [3:0] CSEL_TEX1_ALPHA  = 4'd9;
    localparam logic [3:0] CSEL_PRIM_ALPHA  = 4'd10;
    localparam logic [3:0] CSEL_SHADE_ALPHA = 4'd11;
    localparam logic [3:0] CSEL_ENV_ALPHA   = 4'd12;
    localparam logic [3:0] CSEL_LOD_FRAC    = 4'd13;
    localparam logic [3:0] CSEL_PRIM_LOD    = 4'd14;
    localparam logic [3:0] CSEL_ZERO_K5     = 4'd15;

    // Colour D code that reads zero
    localparam logic [2:0] CSEL_D_ZERO = 3'd7;

    // Alpha selector codes (C reads LOD fraction and prim LOD at combined and one)
    localparam logic [2:0] ASEL_COMBINED = 3'd0;
    localparam logic [2:0] ASEL_TEXEL0   = 3'd1;
    localparam logic [2:0] ASEL_TEXEL1   = 3'd2;
    localparam logic [2:0] ASEL_PRIM     = 3'd3;
    localparam logic [2:0] ASEL_SHADE    = 3'd4;
    localparam logic [2:0] ASEL_ENV      = 3'd5;
    localparam logic [2:0] ASEL_ONE      = 3'd6;
    localparam logic [2:0] ASEL_ZERO     = 3'd7;

    // Operand selectors of one combiner cycle
    typedef struct packed {
        logic [3:0] ca;
        logic [3:0] cb;
        logic [4:0] cc;
        logic [2:0] cd;
        logic [2:0] aa;
        logic [2:0] ab;
        logic [2:0] ac;
        logic [2:0] ad;
    } t_sel;

    // Constant colours shared by both cycles
    typedef struct packed {
        logic [31:0] prim;
        logic [31:0] env;
        logic [7:0]  lod;
    } t_cfg;

    // Pull the selector fields of one cycle out of the two mux words
    function automatic t_sel decode_sel(input logic [23:0] lo, input logic [31:0] hi,
                                        input logic cyc);
        t_sel s;
        if (!cyc) begin
            s.ca = lo[23:20];
            s.cc = lo[19:15];
            s.aa = lo[14:12];
            s.ac = lo[11:9];
            s.cb = hi[31:28];
            s.cd = hi[17:15];
            s.ab = hi[14:12];
            s.ad = hi[11:9];
        end else begin
            s.ca = lo[8:5];
            s.cc = lo[4:0];
            s.cb = hi[27:24];
            s.aa = hi[23:21];
            s.ac = hi[20:18];
            s.cd = hi[8:6];
            s.ab = hi[5:3];
            s.ad = hi[2:0];
        end
        return s;
    endfunction

endpackage

// ===== src/cc_operand_sel.sv =====
// Operand selection stage: picks A, B, C and D for all four lanes of one combiner cycle.
module cc_operand_sel #(
    parameter int CHANNEL_BITS = cc_pkg::CHANNEL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  cc_pkg::t_sel                  i_sel,
    input  cc_pkg::t_cfg                  i_cfg,
    input  logic [31:0]                   i_texel_zero,
    input  logic [31:0]                   i_texel_one,
    input  logic [31:0]                   i_shade_color,
    input  logic signed [CHANNEL_BITS+1:0] i_comb [4],
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [CHANNEL_BITS+1:0] o_a [4],
    output logic signed [CHANNEL_BITS+1:0] o_b [4],
    output logic signed [CHANNEL_BITS+1:0] o_c [4],
    output logic signed [CHANNEL_BITS+1:0] o_d [4],
    output logic [31:0]                   o_texel_zero,
    output logic [31:0]                   o_texel_one,
    output logic [31:0]                   o_shade_color
);

    localparam int OW = CHANNEL_BITS + 2;
    localparam int EW = 4 * CHANNEL_BITS;
    localparam logic signed [OW-1:0] OP_ONE  = {2'b00, {CHANNEL_BITS{1'b1}}};
    localparam logic signed [OW-1:0] OP_ZERO = '0;

    logic [CHANNEL_BITS-1:0] t0 [4];
    logic [CHANNEL_BITS-1:0] t1 [4];
    logic [CHANNEL_BITS-1:0] sh [4];
    logic [CHANNEL_BITS-1:0] pr [4];
    logic [CHANNEL_BITS-1:0] en [4];
    logic signed [OW-1:0]    lod;

    logic signed [OW-1:0] n_a [4];
    logic signed [OW-1:0] n_b [4];
    logic signed [OW-1:0] n_c [4];
    logic signed [OW-1:0] n_d [4];

    logic                 r_valid;
    logic                 adv;
    logic signed [OW-1:0] r_a [4];
    logic signed [OW-1:0] r_b [4];
    logic signed [OW-1:0] r_c [4];
    logic signed [OW-1:0] r_d [4];
    logic [31:0]          r_texel_zero;
    logic [31:0]          r_texel_one;
    logic [31:0]          r_shade_color;

    // Channel of a packed word, red on top; bits beyond the word read zero
    function automatic logic [CHANNEL_BITS-1:0] chan(input logic [31:0] w, input int i);
        logic [EW-1:0] e;
        e = EW'(w);
        return e[(3-i)*CHANNEL_BITS +: CHANNEL_BITS];
    endfunction

    function automatic logic signed [OW-1:0] ext(input logic [CHANNEL_BITS-1:0] v);
        return {2'b00, v};
    endfunction

    // Colour operand of lane ch; k5 gives the C meaning of the top code
    function automatic logic signed [OW-1:0] color_op(input logic [3:0] s, input int ch,
                                                      input logic k5);
        logic signed [OW-1:0] v;
        case (s)
            cc_pkg::CSEL_COMBINED:    v = i_comb[ch];
            cc_pkg::CSEL_TEXEL0:      v = ext(t0[ch]);
            cc_pkg::CSEL_TEXEL1:      v = ext(t1[ch]);
            cc_pkg::CSEL_PRIM:        v = ext(pr[ch]);
            cc_pkg::CSEL_SHADE:       v = ext(sh[ch]);
            cc_pkg::CSEL_ENV:         v = ext(en[ch]);
            cc_pkg::CSEL_ONE:         v = OP_ONE;
            cc_pkg::CSEL_COMB_ALPHA:  v = i_comb[3];
            cc_pkg::CSEL_TEX0_ALPHA:  v = ext(t0[3]);
            cc_pkg::CSEL_TEX1_ALPHA:  v = ext(t1[3]);
            cc_pkg::CSEL_PRIM_ALPHA:  v = ext(pr[3]);
            cc_pkg::CSEL_SHADE_ALPHA: v = ext(sh[3]);
            cc_pkg::CSEL_ENV_ALPHA:   v = ext(en[3]);
            cc_pkg::CSEL_LOD_FRAC:    v = OP_ZERO;
            cc_pkg::CSEL_PRIM_LOD:    v = lod;
            cc_pkg::CSEL_ZERO_K5:     v = k5 ? OP_ONE : OP_ZERO;
            default:                  v = OP_ZERO;
        endcase
        return v;
    endfunction

    // Alpha operand; cin gives the C meaning of combined and one
    function automatic logic signed [OW-1:0] alpha_op(input logic [2:0] s, input logic cin);
        logic signed [OW-1:0] v;
        case (s)
            cc_pkg::ASEL_COMBINED: v = cin ? OP_ZERO : i_comb[3];
            cc_pkg::ASEL_TEXEL0:   v = ext(t0[3]);
            cc_pkg::ASEL_TEXEL1:   v = ext(t1[3]);
            cc_pkg::ASEL_PRIM:     v = ext(pr[3]);
            cc_pkg::ASEL_SHADE:    v = ext(sh[3]);
            cc_pkg::ASEL_ENV:      v = ext(en[3]);
            cc_pkg::ASEL_ONE:      v = cin ? lod : OP_ONE;
            default:               v = OP_ZERO;
        endcase
        return v;
    endfunction

    // Unpack the colour sources
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            t0[i] = chan(i_texel_zero, i);
            t1[i] = chan(i_texel_one, i);
            sh[i] = chan(i_shade_color, i);
            pr[i] = chan(i_cfg.prim, i);
            en[i] = chan(i_cfg.env, i);
        end
        lod = {{(CHANNEL_BITS-6){1'b0}}, i_cfg.lod};
    end

    // Select the operands
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a[i] = color_op(i_sel.ca, i, 1'b0);
            n_b[i] = color_op(i_sel.cb, i, 1'b0);
            n_c[i] = i_sel.cc[4] ? OP_ZERO : color_op(i_sel.cc[3:0], i, 1'b1);
            n_d[i] = (i_sel.cd == cc_pkg::CSEL_D_ZERO) ? OP_ZERO
                                                       : color_op({1'b0, i_sel.cd}, i, 1'b0);
        end
        n_a[3] = alpha_op(i_sel.aa, 1'b0);
        n_b[3] = alpha_op(i_sel.ab, 1'b0);
        n_c[3] = alpha_op(i_sel.ac, 1'b1);
        n_d[3] = alpha_op(i_sel.ad, 1'b0);
    end

    // Advance when empty or when downstream takes the held transaction
    assign adv     = !r_valid || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    // Load the operands
    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_a           <= n_a;
            r_b           <= n_b;
            r_c           <= n_c;
            r_d           <= n_d;
            r_texel_zero  <= i_texel_zero;
            r_texel_one   <= i_texel_one;
            r_shade_color <= i_shade_color;
        end
    end

    assign o_valid       = r_valid;
    assign o_a           = r_a;
    assign o_b           = r_b;
    assign o_c           = r_c;
    assign o_d           = r_d;
    assign o_texel_zero  = r_texel_zero;
    assign o_texel_one   = r_texel_one;
    assign o_shade_color = r_shade_color;

endmodule

// ===== src/cc_combine_unit.sv =====
// Three-stage (A-B)*C+D unit over four lanes with rounding divide by full scale.
module cc_combine_unit #(
    parameter int CHANNEL_BITS = cc_pkg::CHANNEL_BITS_DEF,
    parameter int SIDE_W       = 96
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [CHANNEL_BITS+1:0] i_a [4],
    input  logic signed [CHANNEL_BITS+1:0] i_b [4],
    input  logic signed [CHANNEL_BITS+1:0] i_c [4],
    input  logic signed [CHANNEL_BITS+1:0] i_d [4],
    input  logic [SIDE_W-1:0]              i_side,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [CHANNEL_BITS+1:0] o_res [4],
    output logic [SIDE_W-1:0]              o_side
);

    localparam int OW  = CHANNEL_BITS + 2;       // saturated intermediate
    localparam int PW  = 2 * OW;                 // signed product
    localparam int MW  = 2 * CHANNEL_BITS + 3;   // product magnitude plus rounding
    localparam int SW  = MW + 1;                 // reciprocal series sum
    localparam int QW  = CHANNEL_BITS + 3;       // quotient
    localparam logic signed [OW-1:0] SAT_HI = {1'b0, {(CHANNEL_BITS+1){1'b1}}};
    localparam logic signed [OW-1:0] SAT_LO = {1'b1, {(CHANNEL_BITS+1){1'b0}}};
    localparam logic [MW-1:0] HALF  = MW'((2**(CHANNEL_BITS-1)) - 1);
    localparam logic [SW-1:0] S_ONE = SW'((2**CHANNEL_BITS) - 1);
    localparam logic [QW-1:0] Q_HI  = QW'((2**(CHANNEL_BITS+1)) - 1);
    localparam logic [QW-1:0] Q_LO  = QW'(2**(CHANNEL_BITS+1));

    logic [2:0] r_v;
    logic [2:0] adv;

    // Stage one: difference and product
    logic signed [OW:0]   diff_w [4];
    logic signed [OW-1:0] diff_s [4];
    logic signed [PW-1:0] n1_prod [4];
    logic signed [PW-1:0] r1_prod [4];
    logic signed [OW-1:0] r1_d [4];
    logic [SIDE_W-1:0]    r1_side;

    // Stage two: magnitude and quotient estimate
    logic [PW-1:0]        mag_w [4];
    logic [MW-1:0]        n2_x [4];
    logic [SW-1:0]        sum_w [4];
    logic [QW-1:0]        n2_q [4];
    logic [MW-1:0]        r2_x [4];
    logic [QW-1:0]        r2_q [4];
    logic [3:0]           r2_neg;
    logic signed [OW-1:0] r2_d [4];
    logic [SIDE_W-1:0]    r2_side;

    // Stage three: correction, sign, saturation and D
    logic [SW-1:0]        rem_w [4];
    logic [QW-1:0]        q_fix [4];
    logic [QW-1:0]        q_neg [4];
    logic signed [OW-1:0] prod_s [4];
    logic signed [OW:0]   sum_d [4];
    logic signed [OW-1:0] n3_res [4];
    logic signed [OW-1:0] r3_res [4];
    logic [SIDE_W-1:0]    r3_side;

    function automatic logic signed [OW-1:0] sat1(input logic signed [OW:0] v);
        logic signed [OW-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end else begin
            r = v[OW-1:0];
        end
        return r;
    endfunction

    // Stall chain: a stage moves when it is empty or the next one moves
    always_comb begin
        adv[2] = !r_v[2] || i_ready;
        adv[1] = !r_v[1] || adv[2];
        adv[0] = !r_v[0] || adv[1];
    end
    assign o_ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            if (adv[1]) r_v[1] <= r_v[0];
            if (adv[2]) r_v[2] <= r_v[1];
        end
    end

    // Saturate the difference and multiply by C
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            diff_w[i]  = {i_a[i][OW-1], i_a[i]} - {i_b[i][OW-1], i_b[i]};
            diff_s[i]  = sat1(diff_w[i]);
            n1_prod[i] = diff_s[i] * i_c[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0] && i_valid) begin
            r1_prod <= n1_prod;
            r1_d    <= i_d;
            r1_side <= i_side;
        end
    end

    // Round and estimate the quotient by the series x/2^n + x/2^2n + x/2^3n
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mag_w[i] = r1_prod[i][PW-1] ? (PW'(0) - r1_prod[i]) : r1_prod[i];
            n2_x[i]  = mag_w[i][MW-1:0] + HALF;
            sum_w[i] = SW'(n2_x[i]) + SW'(n2_x[i] >> CHANNEL_BITS)
                     + SW'(n2_x[i] >> (2 * CHANNEL_BITS));
            n2_q[i]  = sum_w[i][CHANNEL_BITS +: QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1] && r_v[0]) begin
            r2_x    <= n2_x;
            r2_q    <= n2_q;
            r2_d    <= r1_d;
            r2_side <= r1_side;
            for (int i = 0; i < 4; i++) begin
                r2_neg[i] <= r1_prod[i][PW-1];
            end
        end
    end

    // Correct the estimate by one where the remainder reaches full scale
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            rem_w[i] = SW'(r2_x[i]) + SW'(r2_q[i]) - (SW'(r2_q[i]) << CHANNEL_BITS);
            q_fix[i] = r2_q[i] + QW'(rem_w[i] >= S_ONE);
            q_neg[i] = QW'(0) - q_fix[i];
            if (!r2_neg[i]) begin
                prod_s[i] = (q_fix[i] > Q_HI) ? SAT_HI : q_fix[i][OW-1:0];
            end else begin
                prod_s[i] = (q_fix[i] > Q_LO) ? SAT_LO : q_neg[i][OW-1:0];
            end
            sum_d[i]  = {prod_s[i][OW-1], prod_s[i]} + {r2_d[i][OW-1], r2_d[i]};
            n3_res[i] = sat1(sum_d[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[2] && r_v[1]) begin
            r3_res  <= n3_res;
            r3_side <= r2_side;
        end
    end

    assign o_valid = r_v[2];
    assign o_res   = r3_res;
    assign o_side  = r3_side;

endmodule

// ===== src/two_cycle_color_combiner_core.sv =====
// Top level of the colour combiner: configuration, pipeline and output clamp.
//
// Usage: each input transaction carries texel zero, texel one and the shade colour of
// one pixel (packed RGBA, red in the top byte). The block runs both combiner cycles,
// (A-B)*C+D on RGB and alpha with operands chosen by the two mux words, and returns one
// packed RGBA pixel, each channel clamped to 0..full scale.
// Configuration: write the mux words, primitive and environment colours and the
// primitive LOD fraction through the write port while no pixel is in flight.
// Pipeline: operand select, three stages of combine, operand select, three stages of
// combine, clamp register; every stage is a register with its own valid bit.
// Throughput: one pixel per clock while the receiver keeps ready high.
// Stall: when the receiver holds ready low, the result stays in the output register and
// the stages behind it keep filling; input ready drops only once every stage is full.
// Reset: clears all valid bits and sets every configuration register to zero.
module two_cycle_color_combiner_core #(
    parameter int CHANNEL_BITS = cc_pkg::CHANNEL_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [cc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [cc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [31:0]                    i_texel_zero,
    input  logic [31:0]                    i_texel_one,
    input  logic [31:0]                    i_shade_color,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [31:0]                    o_pixel_color
);

    localparam int OW = CHANNEL_BITS + 2;
    localparam int EW = 4 * CHANNEL_BITS;
    localparam logic signed [OW-1:0] CH_ONE = {2'b00, {CHANNEL_BITS{1'b1}}};

    logic [23:0] r_mux_low;
    logic [31:0] r_mux_high;
    logic [31:0] r_prim;
    logic [31:0] r_env;
    logic [7:0]  r_lod;

    cc_pkg::t_cfg cfg;
    cc_pkg::t_sel sel0;
    cc_pkg::t_sel sel1;

    logic signed [OW-1:0] comb_zero [4];

    logic                 s0_valid, s0_ready;
    logic signed [OW-1:0] s0_a [4], s0_b [4], s0_c [4], s0_d [4];
    logic [31:0]          s0_t0, s0_t1, s0_sh;

    logic                 u0_valid, u0_ready;
    logic signed [OW-1:0] u0_res [4];
    logic [95:0]          u0_side;

    logic                 s1_valid, s1_ready;
    logic signed [OW-1:0] s1_a [4], s1_b [4], s1_c [4], s1_d [4];
    logic [31:0]          s1_t0, s1_t1, s1_sh;

    logic                 u1_valid, u1_ready;
    logic signed [OW-1:0] u1_res [4];

    logic          out_adv;
    logic          r_out_valid;
    logic [EW-1:0] n_pix;
    logic [31:0]   r_pix;

    // Write the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mux_low  <= '0;
            r_mux_high <= '0;
            r_prim     <= '0;
            r_env      <= '0;
            r_lod      <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                cc_pkg::CFG_MUX_LOW:  r_mux_low  <= i_cfg_data[23:0];
                cc_pkg::CFG_MUX_HIGH: r_mux_high <= i_cfg_data[31:0];
                cc_pkg::CFG_PRIM:     r_prim     <= i_cfg_data[31:0];
                cc_pkg::CFG_ENV:      r_env      <= i_cfg_data[31:0];
                cc_pkg::CFG_LOD:      r_lod      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Decode selectors of both cycles
    always_comb begin
        cfg.prim = r_prim;
        cfg.env  = r_env;
        cfg.lod  = r_lod;
        sel0     = cc_pkg::decode_sel(r_mux_low, r_mux_high, 1'b0);
        sel1     = cc_pkg::decode_sel(r_mux_low, r_mux_high, 1'b1);
        for (int i = 0; i < 4; i++) begin
            comb_zero[i] = '0;
        end
    end

    // Cycle zero: combined reads zero
    cc_operand_sel #(.CHANNEL_BITS(CHANNEL_BITS)) u_sel0 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_sel         (sel0),
        .i_cfg         (cfg),
        .i_texel_zero  (i_texel_zero),
        .i_texel_one   (i_texel_one),
        .i_shade_color (i_shade_color),
        .i_comb        (comb_zero),
        .o_valid       (s0_valid),
        .i_ready       (s0_ready),
        .o_a           (s0_a),
        .o_b           (s0_b),
        .o_c           (s0_c),
        .o_d           (s0_d),
        .o_texel_zero  (s0_t0),
        .o_texel_one   (s0_t1),
        .o_shade_color (s0_sh)
    );

    cc_combine_unit #(.CHANNEL_BITS(CHANNEL_BITS), .SIDE_W(96)) u_comb0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s0_valid),
        .o_ready (s0_ready),
        .i_a     (s0_a),
        .i_b     (s0_b),
        .i_c     (s0_c),
        .i_d     (s0_d),
        .i_side  ({s0_t0, s0_t1, s0_sh}),
        .o_valid (u0_valid),
        .i_ready (u0_ready),
        .o_res   (u0_res),
        .o_side  (u0_side)
    );

    // Cycle one: combined is the cycle zero result
    cc_operand_sel #(.CHANNEL_BITS(CHANNEL_BITS)) u_sel1 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (u0_valid),
        .o_ready       (u0_ready),
        .i_sel         (sel1),
        .i_cfg         (cfg),
        .i_texel_zero  (u0_side[95:64]),
        .i_texel_one   (u0_side[63:32]),
        .i_shade_color (u0_side[31:0]),
        .i_comb        (u0_res),
        .o_valid       (s1_valid),
        .i_ready       (s1_ready),
        .o_a           (s1_a),
        .o_b           (s1_b),
        .o_c           (s1_c),
        .o_d           (s1_d),
        .o_texel_zero  (s1_t0),
        .o_texel_one   (s1_t1),
        .o_shade_color (s1_sh)
    );

    cc_combine_unit #(.CHANNEL_BITS(CHANNEL_BITS), .SIDE_W(96)) u_comb1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_a     (s1_a),
        .i_b     (s1_b),
        .i_c     (s1_c),
        .i_d     (s1_d),
        .i_side  ({s1_t0, s1_t1, s1_sh}),
        .o_valid (u1_valid),
        .i_ready (u1_ready),
        .o_res   (u1_res),
        .o_side  ()
    );

    // Clamp each channel to 0..full scale and pack, red on top
    always_comb begin
        n_pix = '0;
        for (int i = 0; i < 4; i++) begin
            if (u1_res[i] < 0) begin
                n_pix[(3-i)*CHANNEL_BITS +: CHANNEL_BITS] = '0;
            end else if (u1_res[i] > CH_ONE) begin
                n_pix[(3-i)*CHANNEL_BITS +: CHANNEL_BITS] = {CHANNEL_BITS{1'b1}};
            end else begin
                n_pix[(3-i)*CHANNEL_BITS +: CHANNEL_BITS] = u1_res[i][CHANNEL_BITS-1:0];
            end
        end
    end

    // Output register: hold while the receiver stalls
    assign out_adv  = !r_out_valid || i_out_ready;
    assign u1_ready = out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= u1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && u1_valid) begin
            r_pix <= n_pix[31:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_color = r_pix;

    // Pipeline empties on reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Input may only block while the output register holds a valid pixel
    a_block_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input blocked with output register empty");

    // A ready receiver never blocks the input
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input blocked while receiver ready");

endmodule
